[design/obm_pkg.sv]
// shared types and constants for the order book matcher
package obm_pkg;

  localparam int ASK_DEPTH_DEF = 32;
  localparam int BID_DEPTH_DEF = 32;
  localparam int VAL_W         = 40;
  localparam int PROD_W        = 16;
  localparam int TIME_W        = 32;

  typedef enum logic [1:0] {
    OP_ASK   = 2'd0,
    OP_BID   = 2'd1,
    OP_MATCH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] amount;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_M_RDA,
    ST_M_WA,
    ST_M_RDB,
    ST_M_CMP,
    ST_M_END
  } state_t;

endpackage

[design/obm_ram.sv]
// generic single-write, single-read ram with registered read data
module obm_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/order_book_matcher_core.sv]
// top level of the order book matcher: sorted order stores and match walk
//
// channel   direction  handshake               payload
// request   in         start & !busy           op, price, amount, product_code, time_code
// result    out        strobe (one cycle)      sale_valid, sale_price, sale_amount,
//                                              sale_product, sale_time, dropped_orders, last
//
// a load moves each entry it goes before up by one: ST_INS_RD reads it, ST_INS_CMP
// writes it; it ends in ST_INS_RD at the head or in ST_INS_CMP at an entry it goes
// after; the store ram reads one entry per step. a match reads each ask and walks the
// bids, then ends in ST_M_END; each bid visit is a read and a compare, and the bid is
// written back on a sale. a full store drops the load without going busy; op 3 is taken and ignored
// reset clears counts, overflow flag and control; ram contents need no clearing
// results cannot be held off: each sale appears for one cycle on strobe
module order_book_matcher_core #(
  parameter int ASK_DEPTH = obm_pkg::ASK_DEPTH_DEF,
  parameter int BID_DEPTH = obm_pkg::BID_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [obm_pkg::VAL_W-1:0]   price,
  input  logic [obm_pkg::VAL_W-1:0]   amount,
  input  logic [obm_pkg::PROD_W-1:0]  product_code,
  input  logic [obm_pkg::TIME_W-1:0]  time_code,
  output logic                        strobe,
  output logic                        sale_valid,
  output logic [obm_pkg::VAL_W-1:0]   sale_price,
  output logic [obm_pkg::VAL_W-1:0]   sale_amount,
  output logic [obm_pkg::PROD_W-1:0]  sale_product,
  output logic [obm_pkg::TIME_W-1:0]  sale_time,
  output logic                        dropped_orders,
  output logic                        last
);

  localparam int AAW  = (ASK_DEPTH > 1) ? $clog2(ASK_DEPTH) : 1;
  localparam int BAW  = (BID_DEPTH > 1) ? $clog2(BID_DEPTH) : 1;
  localparam int MAXD = (ASK_DEPTH > BID_DEPTH) ? ASK_DEPTH : BID_DEPTH;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int EW   = $bits(obm_pkg::entry_t);
  localparam int VW   = obm_pkg::VAL_W;

  obm_pkg::state_t state, state_next;

  // store fill counts and the overflow flag
  logic [CW-1:0] ask_cnt, ask_cnt_next;
  logic [CW-1:0] bid_cnt, bid_cnt_next;
  logic          ovf, ovf_next;

  // insert request in flight
  logic          ld_bid, ld_bid_next;
  logic [VW-1:0] ld_price, ld_price_next;
  logic [VW-1:0] ld_amount, ld_amount_next;
  logic [CW-1:0] k, k_next;

  // match walk: ask index, bid index, current ask price and remaining amount
  logic [obm_pkg::PROD_W-1:0] prod_r, prod_r_next;
  logic [obm_pkg::TIME_W-1:0] time_r, time_r_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [VW-1:0] ap, ap_next;
  logic [VW-1:0] aa, aa_next;

  // one sale is held back so the final one can carry last
  logic          pend_valid, pend_valid_next;
  logic [VW-1:0] pend_price, pend_price_next;
  logic [VW-1:0] pend_amount, pend_amount_next;

  logic          strobe_next, sale_valid_next, last_next, dropped_orders_next;
  logic [VW-1:0] sale_price_next, sale_amount_next;

  // ram ports
  logic            ask_we, bid_we;
  logic [CW-1:0]   wa, ra;
  obm_pkg::entry_t wr_e, ask_rd, bid_rd, rd_e;
  logic [EW-1:0]   ask_rdata, bid_rdata;
  logic            goes_after;

  obm_ram #(.WIDTH(EW), .DEPTH(ASK_DEPTH)) u_ask_ram (
    .clk   (clk),
    .we    (ask_we),
    .waddr (wa[AAW-1:0]),
    .wdata (wr_e),
    .raddr (ra[AAW-1:0]),
    .rdata (ask_rdata)
  );

  obm_ram #(.WIDTH(EW), .DEPTH(BID_DEPTH)) u_bid_ram (
    .clk   (clk),
    .we    (bid_we),
    .waddr (wa[BAW-1:0]),
    .wdata (wr_e),
    .raddr (ra[BAW-1:0]),
    .rdata (bid_rdata)
  );

  assign ask_rd = obm_pkg::entry_t'(ask_rdata);
  assign bid_rd = obm_pkg::entry_t'(bid_rdata);
  assign rd_e   = ld_bid ? bid_rd : ask_rd;

  // stable order: new order goes after equal prices
  assign goes_after = ld_bid ? (rd_e.price >= ld_price) : (rd_e.price <= ld_price);

  assign busy           = (state != obm_pkg::ST_IDLE);
  assign sale_product   = prod_r;
  assign sale_time      = time_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= obm_pkg::ST_IDLE;
      ask_cnt    <= '0;
      bid_cnt    <= '0;
      ovf        <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      ask_cnt    <= ask_cnt_next;
      bid_cnt    <= bid_cnt_next;
      ovf        <= ovf_next;
      pend_valid <= pend_valid_next;
      strobe     <= strobe_next;
    end
    ld_bid         <= ld_bid_next;
    ld_price       <= ld_price_next;
    ld_amount      <= ld_amount_next;
    k              <= k_next;
    prod_r         <= prod_r_next;
    time_r         <= time_r_next;
    i              <= i_next;
    j              <= j_next;
    ap             <= ap_next;
    aa             <= aa_next;
    pend_price     <= pend_price_next;
    pend_amount    <= pend_amount_next;
    sale_valid     <= sale_valid_next;
    sale_price     <= sale_price_next;
    sale_amount    <= sale_amount_next;
    dropped_orders <= dropped_orders_next;
    last           <= last_next;
  end

  always_comb begin
    state_next          = state;
    ask_cnt_next        = ask_cnt;
    bid_cnt_next        = bid_cnt;
    ovf_next            = ovf;
    ld_bid_next         = ld_bid;
    ld_price_next       = ld_price;
    ld_amount_next      = ld_amount;
    k_next              = k;
    prod_r_next         = prod_r;
    time_r_next         = time_r;
    i_next              = i;
    j_next              = j;
    ap_next             = ap;
    aa_next             = aa;
    pend_valid_next     = pend_valid;
    pend_price_next     = pend_price;
    pend_amount_next    = pend_amount;
    strobe_next         = 1'b0;
    sale_valid_next     = sale_valid;
    sale_price_next     = sale_price;
    sale_amount_next    = sale_amount;
    dropped_orders_next = dropped_orders;
    last_next           = last;
    ask_we              = 1'b0;
    bid_we              = 1'b0;
    wa                  = k;
    ra                  = k;
    wr_e                = rd_e;

    case (state)
      obm_pkg::ST_IDLE: begin
        if (start) begin
          case (obm_pkg::op_t'(op))
            obm_pkg::OP_ASK: begin
              if (ask_cnt >= CW'(ASK_DEPTH)) begin
                ovf_next = 1'b1;
              end else begin
                ld_bid_next    = 1'b0;
                ld_price_next  = price;
                ld_amount_next = amount;
                k_next         = ask_cnt;
                ask_cnt_next   = ask_cnt + 1'b1;
                state_next     = obm_pkg::ST_INS_RD;
              end
            end
            obm_pkg::OP_BID: begin
              if (bid_cnt >= CW'(BID_DEPTH)) begin
                ovf_next = 1'b1;
              end else begin
                ld_bid_next    = 1'b1;
                ld_price_next  = price;
                ld_amount_next = amount;
                k_next         = bid_cnt;
                bid_cnt_next   = bid_cnt + 1'b1;
                state_next     = obm_pkg::ST_INS_RD;
              end
            end
            obm_pkg::OP_MATCH: begin
              prod_r_next     = product_code;
              time_r_next     = time_code;
              i_next          = '0;
              pend_valid_next = 1'b0;
              state_next      = obm_pkg::ST_M_RDA;
            end
            default: begin
            end
          endcase
        end
      end

      // walk down from the tail, moving entries the new order goes before up by one
      obm_pkg::ST_INS_RD: begin
        if (k == '0) begin
          wr_e.price  = ld_price;
          wr_e.amount = ld_amount;
          ask_we      = !ld_bid;
          bid_we      = ld_bid;
          state_next  = obm_pkg::ST_IDLE;
        end else begin
          ra         = k - 1'b1;
          state_next = obm_pkg::ST_INS_CMP;
        end
      end

      obm_pkg::ST_INS_CMP: begin
        ask_we = !ld_bid;
        bid_we = ld_bid;
        if (goes_after) begin
          wr_e.price  = ld_price;
          wr_e.amount = ld_amount;
          state_next  = obm_pkg::ST_IDLE;
        end else begin
          wr_e       = rd_e;
          k_next     = k - 1'b1;
          state_next = obm_pkg::ST_INS_RD;
        end
      end

      obm_pkg::ST_M_RDA: begin
        ra = i;
        if (i == ask_cnt) begin
          state_next = obm_pkg::ST_M_END;
        end else begin
          state_next = obm_pkg::ST_M_WA;
        end
      end

      obm_pkg::ST_M_WA: begin
        ap_next    = ask_rd.price;
        aa_next    = ask_rd.amount;
        j_next     = '0;
        state_next = obm_pkg::ST_M_RDB;
      end

      obm_pkg::ST_M_RDB: begin
        ra = j;
        if (j == bid_cnt) begin
          i_next     = i + 1'b1;
          state_next = obm_pkg::ST_M_RDA;
        end else begin
          state_next = obm_pkg::ST_M_CMP;
        end
      end

      obm_pkg::ST_M_CMP: begin
        wa = j;
        if (bid_rd.price < ap || bid_rd.amount == '0) begin
          // bid too cheap or used up
          j_next     = j + 1'b1;
          state_next = obm_pkg::ST_M_RDB;
        end else begin
          // release the held sale, hold the new one
          if (pend_valid) begin
            strobe_next         = 1'b1;
            sale_valid_next     = 1'b1;
            sale_price_next     = pend_price;
            sale_amount_next    = pend_amount;
            dropped_orders_next = ovf;
            last_next           = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_price_next = ap;
          bid_we          = 1'b1;
          wr_e.price      = bid_rd.price;
          if (bid_rd.amount >= aa) begin
            // ask used up
            pend_amount_next = aa;
            wr_e.amount      = bid_rd.amount - aa;
            i_next           = i + 1'b1;
            state_next       = obm_pkg::ST_M_RDA;
          end else begin
            // bid used up, ask goes on
            pend_amount_next = bid_rd.amount;
            wr_e.amount      = '0;
            aa_next          = aa - bid_rd.amount;
            j_next           = j + 1'b1;
            state_next       = obm_pkg::ST_M_RDB;
          end
        end
      end

      // final result carries the flag seen for this batch, then the batch is cleared
      obm_pkg::ST_M_END: begin
        strobe_next         = 1'b1;
        last_next           = 1'b1;
        sale_valid_next     = pend_valid;
        sale_price_next     = pend_valid ? pend_price : '0;
        sale_amount_next    = pend_valid ? pend_amount : '0;
        dropped_orders_next = ovf;
        pend_valid_next     = 1'b0;
        ask_cnt_next        = '0;
        bid_cnt_next        = '0;
        ovf_next            = 1'b0;
        state_next          = obm_pkg::ST_IDLE;
      end

      default: begin
        state_next = obm_pkg::ST_IDLE;
      end
    endcase
  end

  // a finished run leaves both stores empty
  assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (ask_cnt == '0 && bid_cnt == '0 && !busy))
    else $error("stores not cleared after final result");

  // a non-sale result is always the only and final one
  assert property (@(posedge clk) disable iff (rst)
    (strobe && !sale_valid) |-> last)
    else $error("non-sale result without last");

  // fill counts never pass the store depth
  assert property (@(posedge clk) disable iff (rst)
    (ask_cnt <= CW'(ASK_DEPTH)) && (bid_cnt <= CW'(BID_DEPTH)))
    else $error("store count beyond depth");

endmodule

[sim/testbench.sv]
// self-checking testbench for the order book matcher core
`timescale 1ns / 100ps

module testbench;

  localparam int NA = obm_pkg::ASK_DEPTH_DEF;
  localparam int NB = obm_pkg::BID_DEPTH_DEF;
  localparam int VAL_W  = obm_pkg::VAL_W;
  localparam int PROD_W = obm_pkg::PROD_W;
  localparam int TIME_W = obm_pkg::TIME_W;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]        op;
    logic [VAL_W-1:0]  price;
    logic [VAL_W-1:0]  amount;
    logic [PROD_W-1:0] prod;
    logic [TIME_W-1:0] tcode;
  } request_t;

  typedef struct packed {
    logic              valid;
    logic [VAL_W-1:0]  price;
    logic [VAL_W-1:0]  amount;
    logic [PROD_W-1:0] prod;
    logic [TIME_W-1:0] tcode;
    logic              dropped;
    logic              last;
  } sale_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] op;
  logic [VAL_W-1:0] price;
  logic [VAL_W-1:0] amount;
  logic [PROD_W-1:0] product_code;
  logic [TIME_W-1:0] time_code;
  logic strobe;
  logic sale_valid;
  logic [VAL_W-1:0] sale_price;
  logic [VAL_W-1:0] sale_amount;
  logic [PROD_W-1:0] sale_product;
  logic [TIME_W-1:0] sale_time;
  logic dropped_orders;
  logic last;

  // requests waiting to be sent; a flag holds the sender until all results are in
  request_t pending_reqs[$];
  bit       drain_before[$];
  sale_t    expected_sales[$];

  // book model
  logic [VAL_W-1:0] bk_ask_p[NA];
  logic [VAL_W-1:0] bk_ask_a[NA];
  logic [VAL_W-1:0] bk_bid_p[NB];
  logic [VAL_W-1:0] bk_bid_a[NB];
  int  bk_asks;
  int  bk_bids;
  bit  bk_overflow;

  int     errors;
  int     sales_seen;
  int     matches_sent;
  longint cycles;

  order_book_matcher_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .price(price),
    .amount(amount), .product_code(product_code), .time_code(time_code),
    .strobe(strobe), .sale_valid(sale_valid), .sale_price(sale_price),
    .sale_amount(sale_amount), .sale_product(sale_product), .sale_time(sale_time),
    .dropped_orders(dropped_orders), .last(last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // stable sorted insert: asks ascending, bids descending, ties after
  task automatic book_insert(input bit is_bid, input logic [VAL_W-1:0] p,
                             input logic [VAL_W-1:0] a);
    int pos;
    int n;
    n = is_bid ? bk_bids : bk_asks;
    if (n >= (is_bid ? NB : NA)) begin
      bk_overflow = 1'b1;
      return;
    end
    pos = 0;
    while (pos < n && (is_bid ? (bk_bid_p[pos] >= p) : (bk_ask_p[pos] <= p)))
      pos++;
    for (int k = n; k > pos; k--) begin
      if (is_bid) begin
        bk_bid_p[k] = bk_bid_p[k-1];
        bk_bid_a[k] = bk_bid_a[k-1];
      end else begin
        bk_ask_p[k] = bk_ask_p[k-1];
        bk_ask_a[k] = bk_ask_a[k-1];
      end
    end
    if (is_bid) begin
      bk_bid_p[pos] = p;
      bk_bid_a[pos] = a;
      bk_bids = n + 1;
    end else begin
      bk_ask_p[pos] = p;
      bk_ask_a[pos] = a;
      bk_asks = n + 1;
    end
  endtask

  // walk asks against bids and queue the sales this match should produce
  task automatic book_match(input request_t r);
    sale_t s;
    int    made;
    made = 0;
    s.prod = r.prod;
    s.tcode = r.tcode;
    s.dropped = bk_overflow;
    s.last = 1'b0;
    s.valid = 1'b1;
    for (int i = 0; i < bk_asks; i++) begin
      for (int j = 0; j < bk_bids; j++) begin
        if (bk_bid_p[j] < bk_ask_p[i] || bk_bid_a[j] == '0) continue;
        s.price = bk_ask_p[i];
        if (bk_bid_a[j] >= bk_ask_a[i]) begin
          s.amount = bk_ask_a[i];
          bk_bid_a[j] -= bk_ask_a[i];
          bk_ask_a[i] = '0;
          expected_sales = {expected_sales, s};
          made++;
          break;
        end
        s.amount = bk_bid_a[j];
        bk_ask_a[i] -= bk_bid_a[j];
        bk_bid_a[j] = '0;
        expected_sales = {expected_sales, s};
        made++;
      end
    end
    if (made == 0) begin
      s.valid = 1'b0;
      s.price = '0;
      s.amount = '0;
      expected_sales = {expected_sales, s};
    end
    expected_sales[$].last = 1'b1;
    bk_asks = 0;
    bk_bids = 0;
    bk_overflow = 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: rand_val = '0;
      1: rand_val = '1;
      2: rand_val = VAL_W'({$urandom, $urandom});
      default: rand_val = VAL_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic add_req(input logic [1:0] o, input logic [VAL_W-1:0] p,
                         input logic [VAL_W-1:0] a, input bit drain = 1'b0);
    request_t r;
    r.op = o;
    r.price = p;
    r.amount = a;
    r.prod = PROD_W'($urandom);
    r.tcode = $urandom;
    pending_reqs = {pending_reqs, r};
    drain_before = {drain_before, drain};
  endtask

  function automatic int gap_len();
    int g;
    g = $urandom_range(0, 19);
    if (g < 10) return 0;
    if (g < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: feeds the next request once the core is free, with random gaps
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        // request taken at this edge
        if (pending_reqs.size() != 0 && gap_left == 0 && !drain_before[0]
            && gap_len() == 0) begin
          {op, price, amount, product_code, time_code} <= pending_reqs[0];
          void'(drain_before.pop_front());
          void'(pending_reqs.pop_front());
        end else begin
          start <= 1'b0;
          gap_left <= gap_len();
        end
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
          if (drain_before[0] && expected_sales.size() != 0) begin
            // hold off until the previous match has fully drained
          end else begin
            {op, price, amount, product_code, time_code} <= pending_reqs[0];
            void'(drain_before.pop_front());
            void'(pending_reqs.pop_front());
            start <= 1'b1;
          end
        end
      end
    end
  end

  // predictor runs on accepted requests, checked against strobes
  always @(posedge clk) begin
    request_t r;
    sale_t    got;
    if (!rst) begin
      cycles <= cycles + 1;
      if (strobe) begin
        got = {sale_valid, sale_price, sale_amount, sale_product, sale_time,
               dropped_orders, last};
        sales_seen++;
        if (expected_sales.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected sale %h", got);
        end else begin
          if (got !== expected_sales[0]) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected v=%b p=%h a=%h pr=%h t=%h d=%b l=%b",
                expected_sales[0].valid, expected_sales[0].price,
                expected_sales[0].amount, expected_sales[0].prod,
                expected_sales[0].tcode, expected_sales[0].dropped,
                expected_sales[0].last);
              $display("          got      v=%b p=%h a=%h pr=%h t=%h d=%b l=%b",
                got.valid, got.price, got.amount, got.prod, got.tcode,
                got.dropped, got.last);
            end
          end
          void'(expected_sales.pop_front());
        end
      end
      if (start && !busy) begin
        r = {op, price, amount, product_code, time_code};
        case (obm_pkg::op_t'(r.op))
          obm_pkg::OP_ASK:   book_insert(1'b0, r.price, r.amount);
          obm_pkg::OP_BID:   book_insert(1'b1, r.price, r.amount);
          obm_pkg::OP_MATCH: begin
            book_match(r);
            matches_sent++;
          end
          default: ;
        endcase
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int n;
    errors = 0;
    sales_seen = 0;
    matches_sent = 0;
    cycles = 0;
    bk_asks = 0;
    bk_bids = 0;
    bk_overflow = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    op = obm_pkg::OP_NONE;
    price = '0;
    amount = '0;
    product_code = '0;
    time_code = '0;

    // directed: empty match, extremes, zero ask, used-up bid, ties, op 3
    add_req(obm_pkg::OP_MATCH, '0, '0);
    add_req(obm_pkg::OP_ASK, '1, '1);
    add_req(obm_pkg::OP_BID, '1, '1);
    add_req(obm_pkg::OP_NONE, '1, '1);
    add_req(obm_pkg::OP_MATCH, '0, '0);
    add_req(obm_pkg::OP_ASK, VAL_W'(10), '0);
    add_req(obm_pkg::OP_ASK, VAL_W'(10), VAL_W'(5));
    add_req(obm_pkg::OP_ASK, VAL_W'(5), VAL_W'(7));
    add_req(obm_pkg::OP_BID, VAL_W'(20), VAL_W'(3));
    add_req(obm_pkg::OP_BID, VAL_W'(20), '0);
    add_req(obm_pkg::OP_BID, VAL_W'(10), VAL_W'(9));
    add_req(obm_pkg::OP_BID, VAL_W'(4), VAL_W'(100));
    add_req(obm_pkg::OP_MATCH, '0, '0);
    add_req(obm_pkg::OP_ASK, VAL_W'(50), VAL_W'(10));
    add_req(obm_pkg::OP_BID, VAL_W'(40), VAL_W'(10));
    add_req(obm_pkg::OP_MATCH, '0, '0, 1'b1);
    // fill both stores past depth to trigger overflow
    for (int k = 0; k < NA + 1; k++)
      add_req(obm_pkg::OP_ASK, VAL_W'($urandom_range(0, 8)), rand_val());
    for (int k = 0; k < NB + 1; k++)
      add_req(obm_pkg::OP_BID, VAL_W'($urandom_range(0, 8)), rand_val());
    add_req(obm_pkg::OP_MATCH, '0, '0, 1'b1);

    // random batches: mostly loads with close prices, then a match
    n = 0;
    while (n < 20) begin
      for (int k = $urandom_range(0, 8); k > 0; k--) begin
        if ($urandom_range(0, 9) == 0) add_req(obm_pkg::OP_NONE, rand_val(), rand_val());
        else if ($urandom_range(0, 5) == 0)
          add_req(2'($urandom_range(0, 1)), rand_val(), rand_val());
        else
          add_req(2'($urandom_range(0, 1)), VAL_W'($urandom_range(90, 110)), rand_val());
        n++;
      end
      add_req(obm_pkg::OP_MATCH, '0, '0, $urandom_range(0, 7) == 0);
      n++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_sales.size() == 0);
    repeat (200) @(posedge clk);
    $display("ran %0d match runs, %0d results checked, loads with overflow and ties",
             matches_sent, sales_seen);
    if (errors == 0 && expected_sales.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
design/obm_pkg.sv
design/obm_ram.sv
design/order_book_matcher_core.sv
sim/testbench.sv
